### hw/rtl/md5md_pkg.sv
package md5md_pkg;

    localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
    localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
    localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
    localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef logic [3:0][31:0] md5md_chain_t;

    typedef struct packed {
        logic        wr_en;
        logic [3:0]  wr_addr;
        logic [31:0] wr_data;
        logic        start;
    } md5md_cmp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md5md_cmp_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

    // Per-round rotate amount: four values per group of sixteen rounds.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] amt;
        unique case ({r[5:4], r[1:0]})
            4'b00_00: amt = 5'd7;
            4'b00_01: amt = 5'd12;
            4'b00_10: amt = 5'd17;
            4'b00_11: amt = 5'd22;
            4'b01_00: amt = 5'd5;
            4'b01_01: amt = 5'd9;
            4'b01_10: amt = 5'd14;
            4'b01_11: amt = 5'd20;
            4'b10_00: amt = 5'd4;
            4'b10_01: amt = 5'd11;
            4'b10_10: amt = 5'd16;
            4'b10_11: amt = 5'd23;
            4'b11_00: amt = 5'd6;
            4'b11_01: amt = 5'd10;
            4'b11_10: amt = 5'd15;
            4'b11_11: amt = 5'd21;
        endcase
        return amt;
    endfunction

    // Message word used by round r.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: idx = lo;
            2'd1: idx = 4'(lo * 4'd5 + 4'd1);
            2'd2: idx = 4'(lo * 4'd3 + 4'd5);
            2'd3: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

endpackage

### hw/rtl/md5md_compress.sv
module md5md_compress (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  md5md_pkg::md5md_cmp_ctrl_t    ctrl,
    input  md5md_pkg::md5md_chain_t       chain_in,
    output md5md_pkg::md5md_cmp_stat_t    stat,
    output md5md_pkg::md5md_chain_t       chain_out
);

    localparam logic [1:0] CP_IDLE  = 2'd0;
    localparam logic [1:0] CP_ROUND = 2'd1;
    localparam logic [1:0] CP_ADD   = 2'd2;

    logic [31:0] block_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  rnd_inc;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, ak_reg;
    logic [31:0] f_val, tmp_sum, b_new;

    always_comb begin
        unique case (rnd_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        // a + K was folded in during the previous round (for round 0, when the compression starts).
        tmp_sum = ak_reg + f_val + rd_data_reg;
        b_new   = b_reg + md5md_pkg::rotl32(tmp_sum, md5md_pkg::rot_amount(rnd_reg));
        rnd_inc = rnd_reg + 6'd1;
        // The word for the next round is read during the current round and registered.
        rd_addr = (phase_reg == CP_ROUND) ? md5md_pkg::msg_index(rnd_inc) : 4'd0;
    end

    always_comb begin
        phase_next = phase_reg;
        rnd_next   = rnd_reg;
        unique case (phase_reg)
            CP_IDLE: begin
                if (ctrl.start) begin
                    phase_next = CP_ROUND;
                    rnd_next   = 6'd0;
                end
            end
            CP_ROUND: begin
                rnd_next = rnd_inc;
                if (rnd_reg == 6'd63) begin
                    phase_next = CP_ADD;
                end
            end
            CP_ADD: phase_next = CP_IDLE;
            default: phase_next = CP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= CP_IDLE;
            rnd_reg   <= 6'd0;
        end else begin
            phase_reg <= phase_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == CP_IDLE && ctrl.start) begin
            a_reg  <= chain_in[0];
            b_reg  <= chain_in[1];
            c_reg  <= chain_in[2];
            d_reg  <= chain_in[3];
            ak_reg <= chain_in[0] + md5md_pkg::ROUND_K[0];
        end else if (phase_reg == CP_ROUND) begin
            a_reg  <= d_reg;
            b_reg  <= b_new;
            c_reg  <= b_reg;
            d_reg  <= c_reg;
            ak_reg <= d_reg + md5md_pkg::ROUND_K[rnd_inc];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            block_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_data_reg <= block_mem[rd_addr];
    end

    assign chain_out[0] = chain_in[0] + a_reg;
    assign chain_out[1] = chain_in[1] + b_reg;
    assign chain_out[2] = chain_in[2] + c_reg;
    assign chain_out[3] = chain_in[3] + d_reg;

    assign stat.busy = (phase_reg != CP_IDLE);
    assign stat.done = (phase_reg == CP_ADD);

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> phase_reg == CP_IDLE)
        else $error("compression started while busy");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.wr_en |-> phase_reg == CP_IDLE)
        else $error("block store written during compression");

    a_add_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == CP_ADD |-> $past(rnd_reg) == 6'd63)
        else $error("final add without sixty-four rounds");

    a_add_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == CP_ADD |=> phase_reg == CP_IDLE)
        else $error("final add lasted more than one cycle");

endmodule

### hw/rtl/md5_message_digest_core.sv
// Channel | Direction | tdata       | tuser      | tlast
// s_      | in        | data_byte   | byte_valid | msg_end
// m_      | out       | digest_byte | -          | digest_last
//
// An item without an end mark leaves s_tready high, unless it completes a 64-byte block.
// The item that completes a block starts the compression in its own accepting cycle, and
// s_tready then stays low through it (64 rounds at one round per cycle through the block
// store's read port, one final add). An end item then pads one store word per cycle (the
// last word starts a compression), runs one or two such compressions, and presents 16 digest items,
// one per cycle when m_tready is high. s_tready is low from the end item until the last
// digest item is taken. aresetn is synchronous; the block store needs no clearing after reset.
module md5_message_digest_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] byte_valid
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] digest_byte
    output logic       m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_COMP  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] len_reg, len_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  widx_reg, widx_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic        end_pend_reg, end_pend_next;
    logic        pad_done_reg, pad_done_next;
    logic        final_reg, final_next;
    md5md_pkg::md5md_chain_t chain_reg, chain_next;

    md5md_pkg::md5md_cmp_ctrl_t ctrl;
    md5md_pkg::md5md_cmp_stat_t stat;
    md5md_pkg::md5md_chain_t    chain_sum;

    logic        in_acc, out_acc;
    logic [31:0] word_merge, pad_word, sweep_val;
    logic [63:0] bit_len;
    logic        final_sweep;

    md5md_compress u_compress (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .chain_in  (chain_reg),
        .stat      (stat),
        .chain_out (chain_sum)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign m_tdata  = 8'(chain_reg[ocnt_reg[3:2]] >> {ocnt_reg[1:0], 3'b000});
    assign m_tlast  = (ocnt_reg == 4'd15);

    always_comb begin
        word_merge = (fill_reg[1:0] == 2'd0) ? 32'(s_tdata)
                   : word_reg | (32'(s_tdata) << {fill_reg[1:0], 3'b000});
        pad_word   = (fill_reg[1:0] == 2'd0) ? 32'(md5md_pkg::PAD_BYTE)
                   : word_reg | (32'(md5md_pkg::PAD_BYTE) << {fill_reg[1:0], 3'b000});
        bit_len    = {len_reg, 3'b000};
        // With 56 or more bytes in the block the length goes into a second block.
        final_sweep = pad_done_reg || (fill_reg[5:3] != 3'b111);
        priority if (!pad_done_reg && widx_reg == fill_reg[5:2]) begin
            sweep_val = pad_word;
        end else if (final_sweep && widx_reg == 4'd14) begin
            sweep_val = bit_len[31:0];
        end else if (final_sweep && widx_reg == 4'd15) begin
            sweep_val = bit_len[63:32];
        end else begin
            sweep_val = 32'd0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        word_next     = word_reg;
        widx_next     = widx_reg;
        ocnt_next     = ocnt_reg;
        end_pend_next = end_pend_reg;
        pad_done_next = pad_done_reg;
        final_next    = final_reg;
        chain_next    = chain_reg;
        ctrl          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        word_next     = word_merge;
                        fill_next     = fill_reg + 6'd1;
                        len_next      = len_reg + 61'd1;
                        ctrl.wr_en    = (fill_reg[1:0] == 2'd3);
                        ctrl.wr_addr  = fill_reg[5:2];
                        ctrl.wr_data  = word_merge;
                    end
                    if (s_tuser && fill_reg == 6'd63) begin
                        ctrl.start    = 1'b1;
                        final_next    = 1'b0;
                        end_pend_next = s_tlast;
                        state_next    = ST_COMP;
                    end else if (s_tlast) begin
                        end_pend_next = 1'b1;
                        widx_next     = fill_next[5:2];
                        state_next    = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_addr = widx_reg;
                ctrl.wr_data = sweep_val;
                if (widx_reg == 4'd15) begin
                    ctrl.start    = 1'b1;
                    final_next    = final_sweep;
                    pad_done_next = 1'b1;
                    state_next    = ST_COMP;
                end else begin
                    widx_next = widx_reg + 4'd1;
                end
            end
            ST_COMP: begin
                if (stat.done) begin
                    chain_next = chain_sum;
                    if (final_reg) begin
                        ocnt_next  = 4'd0;
                        state_next = ST_OUT;
                    end else if (end_pend_reg) begin
                        widx_next  = pad_done_reg ? 4'd0 : fill_reg[5:2];
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (ocnt_reg == 4'd15) begin
                        chain_next    = {md5md_pkg::CHAIN_INIT_D, md5md_pkg::CHAIN_INIT_C,
                                         md5md_pkg::CHAIN_INIT_B, md5md_pkg::CHAIN_INIT_A};
                        fill_next     = 6'd0;
                        len_next      = 61'd0;
                        end_pend_next = 1'b0;
                        pad_done_next = 1'b0;
                        final_next    = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        ocnt_next = ocnt_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            len_reg      <= 61'd0;
            widx_reg     <= 4'd0;
            ocnt_reg     <= 4'd0;
            end_pend_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            final_reg    <= 1'b0;
            chain_reg    <= {md5md_pkg::CHAIN_INIT_D, md5md_pkg::CHAIN_INIT_C,
                             md5md_pkg::CHAIN_INIT_B, md5md_pkg::CHAIN_INIT_A};
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            widx_reg     <= widx_next;
            ocnt_reg     <= ocnt_next;
            end_pend_reg <= end_pend_next;
            pad_done_reg <= pad_done_next;
            final_reg    <= final_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input item taken while digest is being delivered");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> stat.busy)
        else $error("compression did not start");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digest item changed while waiting");

endmodule
